/* design/ltmg_pkg.sv */
// ----------------------------------------------------------------------------
// ltmg_pkg
// Shared widths, constants and register codes of the log tone mapper.
// ----------------------------------------------------------------------------
package ltmg_pkg;

   localparam int PIX_W      = 24;
   localparam int GAIN_W     = 32;
   localparam int GAIN_FRAC  = 16;
   localparam int PROD_W     = GAIN_W + PIX_W;
   localparam int WORK_FRAC  = 30;
   localparam int Z_W        = WORK_FRAC + 1;
   localparam int SQ_W       = 2 * Z_W;
   localparam int GRAY_W     = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;
   localparam logic [GRAY_W-1:0] GRAY_MAX   = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USE_SQUARE_ROOT = 1'b0,
      CSR_GAIN            = 1'b1
   } csr_index_type;

endpackage

/* design/ltmg_if.sv */
// ----------------------------------------------------------------------------
// ltmg_if
// Valid/ready channels of the log tone mapper: pixel beats in, gray beats out.
// ----------------------------------------------------------------------------
interface ltmg_req_if;
   logic                       valid;
   logic                       ready;
   logic [ltmg_pkg::PIX_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface ltmg_rsp_if #(parameter int FRAC_BITS = 16);
   logic                        valid;
   logic                        ready;
   logic [FRAC_BITS:0]          mapped_value;
   logic [ltmg_pkg::GRAY_W-1:0] gray_level;

   modport source (output valid, output mapped_value, output gray_level, input ready);
   modport sink   (input valid, input mapped_value, input gray_level, output ready);
endinterface

/* design/ltmg_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// ltmg_sqrt_pipe
// Pipelined integer square root, one root bit per stage, pixel carried along.
// ----------------------------------------------------------------------------
module ltmg_sqrt_pipe #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [ltmg_pkg::PIX_W-1:0]                    in_pixel,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [(ltmg_pkg::PIX_W+FRAC_BITS+1)/2-1:0]    out_root,
   output logic [ltmg_pkg::PIX_W-1:0]                    out_pixel
);

   localparam int RAD_W = ltmg_pkg::PIX_W + FRAC_BITS;
   localparam int RW    = (RAD_W + 1) / 2;
   localparam int PAD_W = 2 * RW;
   localparam int REM_W = RW + 1;
   localparam int TRY_W = RW + 3;

   logic                       valid_ff [RW];
   logic                       adv      [RW];
   logic [REM_W-1:0]           rem_ff   [RW];
   logic [RW-1:0]              root_ff  [RW];
   logic [PAD_W-1:0]           rad_ff   [RW];
   logic [ltmg_pkg::PIX_W-1:0] pix_ff   [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic                       p_valid;
      logic [REM_W-1:0]           p_rem;
      logic [RW-1:0]              p_root;
      logic [PAD_W-1:0]           p_rad;
      logic [ltmg_pkg::PIX_W-1:0] p_pix;
      logic                       nxt_adv;
      logic [TRY_W-1:0]           cur;
      logic [TRY_W-1:0]           trial;
      logic [TRY_W-1:0]           diff;
      logic                       ge;
      logic [REM_W-1:0]           rem_in;
      logic [RW-1:0]              root_in;
      logic [PAD_W-1:0]           rad_in;

      if (k == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_rem   = '0;
         assign p_root  = '0;
         assign p_rad   = PAD_W'({in_pixel, {FRAC_BITS{1'b0}}});
         assign p_pix   = in_pixel;
      end else begin : g_next
         assign p_valid = valid_ff[k-1];
         assign p_rem   = rem_ff[k-1];
         assign p_root  = root_ff[k-1];
         assign p_rad   = rad_ff[k-1];
         assign p_pix   = pix_ff[k-1];
      end

      if (k == RW - 1) begin : g_last
         assign nxt_adv = out_ready;
      end else begin : g_mid
         assign nxt_adv = adv[k+1];
      end

      assign adv[k] = !valid_ff[k] || nxt_adv;

      // bring down two radicand bits, try root*4+1
      always_comb begin
         cur     = {p_rem, p_rad[PAD_W-1 -: 2]};
         trial   = {1'b0, p_root, 2'b01};
         ge      = (cur >= trial);
         diff    = cur - trial;
         rem_in  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
         root_in = {p_root[RW-2:0], ge};
         rad_in  = p_rad << 2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
            pix_ff[k]  <= p_pix;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_pixel = pix_ff[RW-1];

endmodule

/* design/ltmg_log_pipe.sv */
// ----------------------------------------------------------------------------
// ltmg_log_pipe
// Pipelined log2 on [1,2) by repeated squaring, one result bit per stage.
// ----------------------------------------------------------------------------
module ltmg_log_pipe #(
   parameter int FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_sat,
   input  logic [ltmg_pkg::Z_W-1:0]     in_z,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic                         out_sat,
   output logic [FRAC_BITS-1:0]         out_bits
);

   localparam int ZW  = ltmg_pkg::Z_W;
   localparam int SQW = ltmg_pkg::SQ_W;

   logic                 valid_ff [FRAC_BITS];
   logic                 adv      [FRAC_BITS];
   logic                 sat_ff   [FRAC_BITS];
   logic [ZW-1:0]        z_ff     [FRAC_BITS];
   logic [FRAC_BITS-1:0] r_ff     [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
      logic                 p_valid;
      logic                 p_sat;
      logic [ZW-1:0]        p_z;
      logic [FRAC_BITS-1:0] p_r;
      logic                 nxt_adv;
      logic [SQW-1:0]       sq;
      logic                 ge;
      logic [ZW-1:0]        z_in;
      logic [FRAC_BITS-1:0] r_in;

      if (k == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_sat   = in_sat;
         assign p_z     = in_z;
         assign p_r     = '0;
      end else begin : g_next
         assign p_valid = valid_ff[k-1];
         assign p_sat   = sat_ff[k-1];
         assign p_z     = z_ff[k-1];
         assign p_r     = r_ff[k-1];
      end

      if (k == FRAC_BITS - 1) begin : g_last
         assign nxt_adv = out_ready;
      end else begin : g_mid
         assign nxt_adv = adv[k+1];
      end

      assign adv[k] = !valid_ff[k] || nxt_adv;

      // square, a square of two or more halves and yields a one bit
      always_comb begin
         sq   = p_z * p_z;
         ge   = sq[SQW-1];
         z_in = ge ? sq[SQW-1 -: ZW] : sq[SQW-2 -: ZW];
         r_in = {p_r[FRAC_BITS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            sat_ff[k] <= p_sat;
            z_ff[k]   <= z_in;
            r_ff[k]   <= r_in;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[FRAC_BITS-1];
   assign out_sat   = sat_ff[FRAC_BITS-1];
   assign out_bits  = r_ff[FRAC_BITS-1];

endmodule

/* design/log_tone_map_to_gray.sv */
// ----------------------------------------------------------------------------
// log_tone_map_to_gray
// Log tone mapping of pixel intensities to a clamped value and a gray byte.
// ----------------------------------------------------------------------------
// Accepts one pixel beat per clock while input is not stalled and returns one
// result beat per pixel, in order. The pipeline has one stage per square-root
// bit, one for the gain multiply, one for the saturation check and alignment,
// one squaring stage per log2 result bit and the output register. Every stage
// holds its beat while the next one is full and stalled, so bubbles close up
// and a stalled output stops input only once the pipeline has filled. The
// square root runs on every beat and is selected by use_square_root at the
// multiplier; the user must write configuration only while no beat is in
// flight, as the block itself does not enforce it.
module log_tone_map_to_gray #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   ltmg_req_if.sink                             req_chan,
   ltmg_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [ltmg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ltmg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int RW  = (ltmg_pkg::PIX_W + FRAC_BITS + 1) / 2;
   localparam int TOT = FRAC_BITS + ltmg_pkg::GAIN_FRAC;
   localparam int ZW  = ltmg_pkg::Z_W;
   localparam logic [FRAC_BITS:0] MAPPED_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // configuration registers
   logic                          use_sqrt_ff;
   logic [ltmg_pkg::GAIN_W-1:0]   gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_sqrt_ff <= 1'b0;
         gain_ff     <= ltmg_pkg::GAIN_RESET;
      end else if (csr_we) begin
         unique case (ltmg_pkg::csr_index_type'(csr_index))
            ltmg_pkg::CSR_USE_SQUARE_ROOT: begin
               use_sqrt_ff <= csr_wdata[0];
            end
            ltmg_pkg::CSR_GAIN: begin
               gain_ff <= csr_wdata[ltmg_pkg::GAIN_W-1:0];
            end
         endcase
      end
   end

   // square root
   logic                          sqrt_valid;
   logic                          sqrt_ready;
   logic [RW-1:0]                 sqrt_root;
   logic [ltmg_pkg::PIX_W-1:0]    sqrt_pixel;

   ltmg_sqrt_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_pixel  (req_chan.pixel_value),
      .out_valid (sqrt_valid),
      .out_ready (sqrt_ready),
      .out_root  (sqrt_root),
      .out_pixel (sqrt_pixel)
   );

   // gain multiply
   logic                          mul_valid_ff;
   logic                          mul_adv;
   logic [ltmg_pkg::PIX_W-1:0]    mul_src;
   logic [ltmg_pkg::PROD_W-1:0]   prod_in;
   logic [ltmg_pkg::PROD_W-1:0]   prod_ff;

   // alignment to the log working format
   logic                          aln_valid_ff;
   logic                          aln_adv;
   logic                          aln_sat_in;
   logic [TOT:0]                  aln_y;
   logic [ZW-1:0]                 aln_z_in;
   logic                          aln_sat_ff;
   logic [ZW-1:0]                 aln_z_ff;

   // log and output
   logic                          log_in_ready;
   logic                          log_valid;
   logic                          log_sat;
   logic [FRAC_BITS-1:0]          log_bits;
   logic                          out_valid_ff;
   logic                          out_adv;
   logic [FRAC_BITS:0]            mapped_in;
   logic [FRAC_BITS+8:0]          scaled;
   logic [ltmg_pkg::GRAY_W-1:0]   gray_in;
   logic [FRAC_BITS:0]            mapped_ff;
   logic [ltmg_pkg::GRAY_W-1:0]   gray_ff;

   assign out_adv    = !out_valid_ff || rsp_chan.ready;
   assign aln_adv    = !aln_valid_ff || log_in_ready;
   assign mul_adv    = !mul_valid_ff || aln_adv;
   assign sqrt_ready = mul_adv;

   assign mul_src = use_sqrt_ff ? ltmg_pkg::PIX_W'(sqrt_root) : sqrt_pixel;
   assign prod_in = gain_ff * mul_src;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_adv) begin
         mul_valid_ff <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_adv) begin
         prod_ff <= prod_in;
      end
   end

   // below one the product plus one is a leading one over the fraction bits
   assign aln_sat_in = |prod_ff[ltmg_pkg::PROD_W-1:TOT];
   assign aln_y      = {1'b1, prod_ff[TOT-1:0]};

   if (TOT >= ltmg_pkg::WORK_FRAC) begin : g_trunc
      assign aln_z_in = aln_y[TOT -: ZW];
   end else begin : g_widen
      assign aln_z_in = {aln_y, {(ltmg_pkg::WORK_FRAC - TOT){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aln_valid_ff <= 1'b0;
      end else if (aln_adv) begin
         aln_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (aln_adv) begin
         aln_sat_ff <= aln_sat_in;
         aln_z_ff   <= aln_z_in;
      end
   end

   ltmg_log_pipe #(
      .FRAC_BITS (FRAC_BITS)
   ) u_log (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (aln_valid_ff),
      .in_ready  (log_in_ready),
      .in_sat    (aln_sat_ff),
      .in_z      (aln_z_ff),
      .out_valid (log_valid),
      .out_ready (out_adv),
      .out_sat   (log_sat),
      .out_bits  (log_bits)
   );

   // gray = mapped * 255 >> FRAC_BITS
   assign mapped_in = log_sat ? MAPPED_ONE : {1'b0, log_bits};
   assign scaled    = {mapped_in, 8'b0} - (FRAC_BITS + 9)'(mapped_in);
   assign gray_in   = scaled[FRAC_BITS +: ltmg_pkg::GRAY_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= log_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         mapped_ff <= mapped_in;
         gray_ff   <= gray_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.mapped_value = mapped_ff;
   assign rsp_chan.gray_level   = gray_ff;

   // input can only be held off by a result beat waiting at the output
   a_stall_from_output: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("input stalled without a waiting result beat");

   a_mapped_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.mapped_value <= MAPPED_ONE)
      else $error("mapped value above one");

   a_gray_full: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.mapped_value == MAPPED_ONE
         |-> rsp_chan.gray_level == ltmg_pkg::GRAY_MAX)
      else $error("saturated beat without full gray level");

endmodule
